@@ rtl/fdd_pkg.sv @@
package fdd_pkg;

  localparam int SW          = 32;
  localparam int FRAC        = 16;
  localparam int TOL_W       = 31;
  localparam int MODE_W      = 2;
  localparam int DEN_W       = SW + 2;
  localparam int NUM_W       = SW + 1 + FRAC;
  localparam int CNT_W       = $clog2(SW);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int IN_TDATA_W  = ((2 * SW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SW + 2 + 7) / 8) * 8;

  localparam logic [SW-1:0] SLOPE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SLOPE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FEW    = 2'd1,
    ST_UNEVEN = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_MODE = 1'b0,
    REG_TOL  = 1'b1
  } reg_idx_t;

  localparam logic [MODE_W-1:0] MODE_CENTRAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BWD     = 2'd2;

  // one division (or one error report) for the back end
  typedef struct packed {
    logic             err;
    status_t          status;
    logic [SW:0]      num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             neg;
    logic             last_a;   // tlast of the first copy
    logic             dup;      // emit the slope a second time
    logic             last_b;   // tlast of the second copy
  } job_t;

endpackage

@@ rtl/fdd_front.sv @@
module fdd_front
  import fdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SW-1:0]    x_value,
  input  logic [SW-1:0]    y_value,
  input  logic             last_sample,
  input  logic             cfg_valid,
  input  reg_idx_t         cfg_index,
  input  logic [TOL_W-1:0] cfg_data,
  output logic             push_valid,
  input  logic             push_ready,
  output job_t             push_job
);

  logic [MODE_W-1:0] mode_r;
  logic [TOL_W-1:0]  tol_r;
  logic [SW-1:0]     prior_x_r, prior_y_r, older_y_r;
  logic [SW:0]       first_step_r, first_step_nxt;
  logic [1:0]        pts_r, pts_nxt;
  logic              skip_r, skip_nxt;
  logic              pend_r, pend_nxt;
  job_t              pend_job_r, pend_job_nxt;
  logic              shift_en;
  logic              acc;
  logic              job_v;
  job_t              job;
  logic              central;
  logic [SW:0]       xe, pxe, ye, pye, oye;
  logic [SW:0]       step, dy_prior, dy_older;
  logic [SW+1:0]     dev, adev;
  logic              uneven;

  function automatic job_t mk_div(input logic [SW:0] dy, input logic [SW:0] dx,
                                  input logic twice, input logic la,
                                  input logic dup, input logic lb);
    job_t        j;
    logic [SW:0] ady;
    logic [SW:0] adx;
    ady = dy[SW] ? -dy : dy;
    adx = dx[SW] ? -dx : dx;
    j.err     = 1'b0;
    j.status  = ST_OK;
    j.num_mag = ady;
    j.den_mag = twice ? {adx, 1'b0} : {1'b0, adx};
    j.neg     = dy[SW] ^ dx[SW];
    j.last_a  = la;
    j.dup     = dup;
    j.last_b  = lb;
    return j;
  endfunction

  function automatic job_t mk_err(input status_t st);
    job_t j;
    j         = '0;
    j.err     = 1'b1;
    j.status  = st;
    j.last_a  = 1'b1;
    return j;
  endfunction

  assign in_tready  = !pend_r && push_ready;
  assign acc        = in_tvalid && in_tready;
  assign push_valid = acc ? job_v : pend_r;
  assign push_job   = acc ? job : pend_job_r;
  assign central    = (mode_r != MODE_FWD) && (mode_r != MODE_BWD);

  always_comb begin
    xe       = {x_value[SW-1], x_value};
    pxe      = {prior_x_r[SW-1], prior_x_r};
    ye       = {y_value[SW-1], y_value};
    pye      = {prior_y_r[SW-1], prior_y_r};
    oye      = {older_y_r[SW-1], older_y_r};
    step     = xe - pxe;
    dy_prior = ye - pye;
    dy_older = ye - oye;
    dev      = {step[SW], step} - {first_step_r[SW], first_step_r};
    adev     = dev[SW+1] ? -dev : dev;
    uneven   = adev > (SW+2)'(tol_r);
  end

  always_comb begin
    job_v          = 1'b0;
    job            = mk_err(ST_FEW);
    pts_nxt        = pts_r;
    skip_nxt       = skip_r;
    first_step_nxt = first_step_r;
    shift_en       = 1'b0;
    pend_nxt       = pend_r && !push_ready;
    pend_job_nxt   = pend_job_r;
    if (acc) begin
      if (skip_r) begin
        if (last_sample) begin
          skip_nxt = 1'b0;
          pts_nxt  = 2'd0;
        end
      end else if (pts_r == 2'd0) begin
        if (last_sample) begin
          job_v = 1'b1;
          job   = mk_err(ST_FEW);
        end else begin
          shift_en = 1'b1;
          pts_nxt  = 2'd1;
        end
      end else if (pts_r == 2'd1) begin
        if (central && last_sample) begin
          job_v = 1'b1;
          job   = mk_err(ST_FEW);
        end else if (step == '0) begin
          job_v = 1'b1;
          job   = mk_err(ST_ZERO);
        end else begin
          job_v          = 1'b1;
          first_step_nxt = step;
          shift_en       = 1'b1;
          if (central) begin
            job = mk_div(dy_prior, step, 1'b0, 1'b0, 1'b0, 1'b0);
          end else if (mode_r == MODE_FWD) begin
            job = mk_div(dy_prior, step, 1'b0, last_sample, last_sample, 1'b1);
          end else begin
            job = mk_div(dy_prior, step, 1'b0, 1'b0, 1'b1, last_sample);
          end
        end
      end else if (central) begin
        if (uneven) begin
          job_v = 1'b1;
          job   = mk_err(ST_UNEVEN);
        end else begin
          job_v    = 1'b1;
          shift_en = 1'b1;
          job      = mk_div(dy_older, first_step_r, 1'b1, 1'b0, 1'b0, 1'b0);
          if (last_sample) begin
            pend_nxt     = 1'b1;
            pend_job_nxt = mk_div(dy_prior, first_step_r, 1'b0, 1'b1, 1'b0, 1'b0);
          end
        end
      end else begin
        if (step == '0) begin
          job_v = 1'b1;
          job   = mk_err(ST_ZERO);
        end else begin
          job_v    = 1'b1;
          shift_en = 1'b1;
          if (mode_r == MODE_FWD) begin
            job = mk_div(dy_prior, step, 1'b0, 1'b0, last_sample, 1'b1);
          end else begin
            job = mk_div(dy_prior, step, 1'b0, last_sample, 1'b0, 1'b0);
          end
        end
      end
      if (job_v && job.err) begin
        skip_nxt = !last_sample;
        pts_nxt  = 2'd0;
      end else if (shift_en && pts_r != 2'd0) begin
        pts_nxt = last_sample ? 2'd0 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CENTRAL;
      tol_r  <= TOL_W'(1);
      pts_r  <= 2'd0;
      skip_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
          REG_TOL:  tol_r  <= cfg_data;
          default:  tol_r  <= tol_r;
        endcase
      end
      pts_r  <= pts_nxt;
      skip_r <= skip_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_step_r <= first_step_nxt;
    pend_job_r   <= pend_job_nxt;
    if (shift_en) begin
      older_y_r <= prior_y_r;
      prior_x_r <= x_value;
      prior_y_r <= y_value;
    end
  end

endmodule

@@ rtl/fdd_queue.sv @@
module fdd_queue
  import fdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

@@ rtl/fdd_back.sv @@
module fdd_back
  import fdd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  job_t          pop_job,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [SW-1:0] slope,
  output status_t       status,
  output logic          last_result
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIN, S_EMIT, S_EMIT2} state_t;

  state_t            state_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [SW-1:0]     shf_r, res_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r, last_a_r, dup_r, last_b_r;
  status_t           status_r;
  logic              out_tvalid_r, last_result_r;
  logic [SW-1:0]     slope_r;
  status_t           status_out_r;
  logic [NUM_W-1:0]  num;
  logic [FRAC:0]     num_hi;
  logic [DEN_W:0]    trial, diff;
  logic              ge;
  logic [SW-1:0]     sat;
  logic              out_free;
  logic              emit;

  assign out_tvalid  = out_tvalid_r;
  assign slope       = slope_r;
  assign status      = status_out_r;
  assign last_result = last_result_r;
  assign pop_ready   = state_r == S_IDLE;
  assign out_free    = !out_tvalid_r || out_tready;
  assign emit        = (state_r inside {S_EMIT, S_EMIT2}) && out_free;

  always_comb begin
    num    = NUM_W'(pop_job.num_mag) << FRAC;
    num_hi = num[NUM_W-1:SW];
    trial  = {rem_r, shf_r[SW-1]};
    diff   = trial - {1'b0, den_r};
    ge     = trial >= {1'b0, den_r};
    if (!neg_r) begin
      sat = shf_r[SW-1] ? SLOPE_MAX : shf_r;
    end else begin
      sat = (shf_r[SW-1] && |shf_r[SW-2:0]) ? SLOPE_MIN : -shf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            neg_r    <= pop_job.neg;
            last_a_r <= pop_job.last_a;
            dup_r    <= pop_job.dup;
            last_b_r <= pop_job.last_b;
            status_r <= pop_job.status;
            den_r    <= pop_job.den_mag;
            if (pop_job.err || pop_job.den_mag == '0) begin
              res_r   <= '0;
              state_r <= S_EMIT;
            end else if (DEN_W'(num_hi) >= pop_job.den_mag) begin
              res_r   <= pop_job.neg ? SLOPE_MIN : SLOPE_MAX;
              state_r <= S_EMIT;
            end else begin
              rem_r   <= DEN_W'(num_hi);
              shf_r   <= num[SW-1:0];
              cnt_r   <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          shf_r <= {shf_r[SW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SW - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          res_r   <= sat;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            slope_r       <= res_r;
            status_out_r  <= status_r;
            last_result_r <= last_a_r;
            state_r       <= dup_r ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            slope_r       <= res_r;
            status_out_r  <= status_r;
            last_result_r <= last_b_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/finite_difference_derivative.sv @@
// First derivative of a sample stream (Q16.16 x and y in, saturated Q16.16 slope out).
// The front end takes one sample per cycle unless the queue is full or a closing job is
// pending, and turns it into division jobs or an error report; a two-entry job queue
// decouples it from the back end, a radix-2 restoring divider producing one quotient bit
// per cycle. A slope passes the back end as load, 32 iterations, saturation, output load;
// a quotient known to saturate and an error report skip iteration and saturation.
// The central-mode closing sample needs two divisions. The output register lets the next
// job run while a result waits for out_tready.
module finite_difference_derivative
  import fdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // x_value, y_value
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slope, status, zero pad
  output logic                   out_tlast,  // last_result
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  reg_idx_t               cfg_index,
  input  logic [TOL_W-1:0]       cfg_data
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  job_t          push_job, pop_job;
  logic [SW-1:0] slope;
  status_t       status;

  assign cfg_ready = 1'b1;
  assign out_tdata = OUT_TDATA_W'({status, slope});

  fdd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .x_value     (in_tdata[SW-1:0]),
    .y_value     (in_tdata[2*SW-1:SW]),
    .last_sample (in_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  fdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  fdd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .slope       (slope),
    .status      (status),
    .last_result (out_tlast)
  );

endmodule

@@ rtl/fdd_checker.sv @@
module fdd_checker
  import fdd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SW+1:SW] != ST_OK |-> out_tdata[SW-1:0] == '0 && out_tlast)
    else $error("error result must carry zero slope and tlast");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:SW+2] == '0)
    else $error("tdata pad bits not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind finite_difference_derivative fdd_checker u_fdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ bench/slope_checker.sv @@
module slope_checker
  import fdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  reg_idx_t               cfg_index,
  input  logic [TOL_W-1:0]       cfg_data,
  output int                     mismatch_count,
  output int                     pending_count,
  output int                     samples_used,
  output int                     results_seen,
  output int                     error_reports
);

  typedef struct {
    logic [SW-1:0] slope;
    status_t       status;
    logic          last;
  } slope_item_t;

  slope_item_t slope_queue[$];

  logic [MODE_W-1:0]  mode_q;
  logic [TOL_W-1:0]   tol_q;
  logic [SW-1:0]      older_y_q, prior_x_q, prior_y_q;
  logic signed [SW:0] base_step;
  logic [1:0]         seen_cnt;
  logic               skip_rest;

  int mismatches, used, checked, errs;

  function automatic logic signed [SW:0] signed_gap(logic [SW-1:0] a, logic [SW-1:0] b);
    return $signed({a[SW-1], a}) - $signed({b[SW-1], b});
  endfunction

  // (dy << FRAC) / (dx or 2*dx), truncated toward zero, saturated
  function automatic logic [SW-1:0] fixed_quotient(logic signed [SW:0] dy,
                                                   logic signed [SW:0] dx, logic twice);
    logic signed [SW:0] ay, ax;
    logic [63:0]        num, den, q;
    logic               neg;
    neg = dy[SW] ^ dx[SW];
    ay = dy[SW] ? -dy : dy;
    ax = dx[SW] ? -dx : dx;
    num = {{(63-SW){1'b0}}, ay} << FRAC;
    den = {{(63-SW){1'b0}}, ax};
    if (twice) den = den << 1;
    if (den == 0) return '0;
    q = num / den;
    if (!neg) return (q > {33'b0, SLOPE_MAX[SW-2:0]}) ? SLOPE_MAX : q[SW-1:0];
    if (q > {32'b0, SLOPE_MIN}) q = {32'b0, SLOPE_MIN};
    return -q[SW-1:0];
  endfunction

  function automatic void expect_result(logic [SW-1:0] s, status_t st, logic lst);
    slope_item_t it;
    it.slope = s;
    it.status = st;
    it.last = lst;
    slope_queue.push_back(it);
  endfunction

  function automatic void expect_error(status_t st, logic lst);
    expect_result('0, st, 1'b1);
    skip_rest = !lst;
    seen_cnt = 2'd0;
  endfunction

  function automatic void take_sample(logic [SW-1:0] x, logic [SW-1:0] y, logic lst);
    logic               central;
    logic signed [SW:0] stp;
    logic signed [SW+1:0] dev;
    logic [SW-1:0]      s;
    central = !(mode_q == MODE_FWD || mode_q == MODE_BWD);
    if (skip_rest) begin
      if (lst) begin
        skip_rest = 1'b0;
        seen_cnt = 2'd0;
      end
      return;
    end
    used++;
    if (seen_cnt == 2'd0) begin
      if (lst) begin
        expect_error(ST_FEW, lst);
        return;
      end
      prior_x_q = x;
      prior_y_q = y;
      seen_cnt = 2'd1;
      return;
    end
    stp = signed_gap(x, prior_x_q);
    if (seen_cnt == 2'd1) begin
      if (central && lst) begin
        expect_error(ST_FEW, lst);
        return;
      end
      if (stp == 0) begin
        expect_error(ST_ZERO, lst);
        return;
      end
      base_step = stp;
      s = fixed_quotient(signed_gap(y, prior_y_q), stp, 1'b0);
      if (central) begin
        expect_result(s, ST_OK, 1'b0);
      end else if (mode_q == MODE_FWD) begin
        expect_result(s, ST_OK, lst);
        if (lst) expect_result(s, ST_OK, 1'b1);
      end else begin
        expect_result(s, ST_OK, 1'b0);
        expect_result(s, ST_OK, lst);
      end
    end else if (central) begin
      dev = stp - base_step;
      if (dev < 0) dev = -dev;
      if (dev > $signed({3'b0, tol_q})) begin
        expect_error(ST_UNEVEN, lst);
        return;
      end
      expect_result(fixed_quotient(signed_gap(y, older_y_q), base_step, 1'b1), ST_OK, 1'b0);
      if (lst)
        expect_result(fixed_quotient(signed_gap(y, prior_y_q), base_step, 1'b0), ST_OK, 1'b1);
    end else begin
      if (stp == 0) begin
        expect_error(ST_ZERO, lst);
        return;
      end
      s = fixed_quotient(signed_gap(y, prior_y_q), stp, 1'b0);
      if (mode_q == MODE_FWD) begin
        expect_result(s, ST_OK, 1'b0);
        if (lst) expect_result(s, ST_OK, 1'b1);
      end else begin
        expect_result(s, ST_OK, lst);
      end
    end
    older_y_q = prior_y_q;
    prior_x_q = x;
    prior_y_q = y;
    seen_cnt = lst ? 2'd0 : 2'd2;
  endfunction

  always @(posedge clk) begin
    slope_item_t want;
    if (!rst_n) begin
      slope_queue.delete();
      mode_q = MODE_CENTRAL;
      tol_q = TOL_W'(1);
      older_y_q = '0;
      prior_x_q = '0;
      prior_y_q = '0;
      base_step = '0;
      seen_cnt = 2'd0;
      skip_rest = 1'b0;
      mismatches = 0;
      used = 0;
      checked = 0;
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (out_tdata[SW+1:SW] != ST_OK) errs++;
        if (slope_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer: slope=%h status=%0d last=%b", $time,
                   out_tdata[SW-1:0], out_tdata[SW+1:SW], out_tlast);
        end else begin
          want = slope_queue.pop_front();
          if (out_tdata[SW-1:0] !== want.slope || out_tdata[SW+1:SW] !== want.status ||
              out_tlast !== want.last) begin
            mismatches++;
            $display("%0t: expected slope=%h status=%0d last=%b, got slope=%h status=%0d last=%b",
                     $time, want.slope, want.status, want.last, out_tdata[SW-1:0],
                     out_tdata[SW+1:SW], out_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: mode_q = cfg_data[MODE_W-1:0];
          REG_TOL:  tol_q = cfg_data;
          default:  ;
        endcase
      end
      if (in_tvalid && in_tready)
        take_sample(in_tdata[SW-1:0], in_tdata[2*SW-1:SW], in_tlast);
    end
    mismatch_count <= mismatches;
    pending_count <= slope_queue.size();
    samples_used <= used;
    results_seen <= checked;
    error_reports <= errs;
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  import fdd_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 110;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;      // x_value, y_value
  logic                   in_tlast = 1'b0;    // last_sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // slope, status, zero pad
  logic                   out_tlast;          // last_result
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  reg_idx_t               cfg_index = REG_MODE;
  logic [TOL_W-1:0]       cfg_data = '0;

  int mismatch_count, pending_count, samples_used, results_seen, error_reports;
  int send_idle_pct = 37;
  int recv_idle_pct = 56;
  int stall_epoch = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [TOL_W-1:0] tol_now = TOL_W'(1);

  always #4 clk = ~clk;

  finite_difference_derivative u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slope_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .pending_count(pending_count),
    .samples_used(samples_used), .results_seen(results_seen), .error_reports(error_reports)
  );

  always @(posedge clk) begin
    if (stall_epoch != stall_seen) begin
      stall_seen <= stall_epoch;
      stall_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[finite_difference_derivative] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [SW-1:0] spread_value();
    logic [SW-1:0] v;
    v = $urandom >> $urandom_range(31);
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_sample(logic [SW-1:0] xv, logic [SW-1:0] yv, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {yv, xv};
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(logic [MODE_W-1:0] m, logic [TOL_W-1:0] t);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data <= {{(TOL_W-MODE_W){1'b0}}, m};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_TOL;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_now = t;
  endtask

  // mostly clean series with random content; some flawed, some pure noise
  task automatic send_series();
    int n, pick, flaw_at, jr, i;
    logic [SW-1:0] xv, yv, h, stp;
    logic flaw_zero;
    pick = $urandom_range(99);
    n = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    xv = spread_value();
    yv = ($urandom_range(1) == 0) ? $urandom : spread_value();
    h = $urandom >> $urandom_range(8, 31);
    if (h == 0) h = 1;
    if ($urandom_range(1) == 1) h = -h;
    jr = (tol_now > 1000) ? 1000 : int'(tol_now);
    flaw_at = -1;
    flaw_zero = 1'($urandom_range(1));
    if (pick >= 90) begin
      for (i = 0; i < n; i++)
        send_sample($urandom, $urandom, $urandom_range(3) == 0);
    end else begin
      if (pick >= 70) begin
        if ($urandom_range(2) == 0) begin
          n = $urandom_range(1, 2);
        end else begin
          if (n < 3) n = 3;
          flaw_at = $urandom_range(1, n - 1);
        end
      end
      for (i = 0; i < n; i++) begin
        if (i > 0) begin
          stp = h;
          if (i >= 2 && jr > 0) stp = h + $urandom_range(0, 2 * jr) - jr;
          if (i == flaw_at) stp = flaw_zero ? '0 : h + tol_now + 1 + $urandom_range(255);
          xv = xv + stp;
          yv = ($urandom_range(4) == 0) ? $urandom : yv + spread_value();
        end
        send_sample(xv, yv, i == n - 1);
      end
    end
  endtask

  initial begin
    int p, target;
    logic [TOL_W-1:0] t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // central mode, reset tolerance
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 32'h0002_0000, 1'b1);
    send_sample(32'h0000_0005, 32'h0000_0003, 1'b0);
    send_sample(32'h0000_0005, 32'h0000_0004, 1'b0);
    send_sample(32'h0000_0009, 32'h0000_0001, 1'b1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0001, 32'h8000_0000, 1'b0);
    send_sample(32'h8000_0002, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFE_FFFF, 32'h0001_0000, 1'b0);
    send_sample(32'h7FFD_FFFF, 32'hFFFF_0000, 1'b1);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 32'h0000_0100, 1'b0);
    send_sample(32'h0003_0000, 32'h0000_0200, 1'b0);
    send_sample(32'h0004_0000, 32'h0000_0000, 1'b1);
    send_sample(32'h0000_0100, 32'h0000_0005, 1'b0);
    send_sample(32'h0000_0101, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0101, 32'h8000_0000, 1'b1);
    drain();
    configure(MODE_FWD, TOL_W'(1));
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 32'h0003_0000, 1'b1);
    send_sample(32'h0000_0007, 32'h0000_0001, 1'b0);
    send_sample(32'h0000_0007, 32'h0000_0002, 1'b1);
    drain();
    configure(MODE_BWD, TOL_W'(1));
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_0000, 32'h0001_0000, 1'b1);

    for (p = 0; p < 9; p++) begin
      drain();
      if (p == 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 37;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: t = '0;
        1: t = {TOL_W{1'b1}};
        default: begin
          case ($urandom_range(2))
            0: t = TOL_W'($urandom_range(0, 16));
            1: t = TOL_W'($urandom_range(0, 32'h0001_0000));
            default: t = TOL_W'($urandom);
          endcase
        end
      endcase
      configure(p[MODE_W-1:0], t);
      if (p == 6) stall_epoch++;
      target = samples_used + PHASE_ITEMS;
      while (samples_used < target) send_series();
    end
    drain();

    $display("covered %0d samples taken in, %0d results checked, %0d of them error reports",
             samples_used, results_seen, error_reports);
    $display("all four mode codes, tolerance from zero to full scale, long output hold-off");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[finite_difference_derivative] OK");
    end else begin
      $display("[finite_difference_derivative] ERROR");
    end
    $finish;
  end

endmodule
